### sv/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Shared widths, key codes, display opcodes and the controller/datapath
// command and status types of the paged text display editor.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int KEY_W      = 8;
	localparam int OP_W       = 2;
	localparam int COL_OUT_W  = 4;
	localparam int LINE_OUT_W = 1;
	localparam int PAGE_OUT_W = 3;

	localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd8;
	localparam logic [KEY_W-1:0] KEY_NEWLINE   = 8'd10;
	localparam logic [KEY_W-1:0] KEY_RETURN    = 8'd13;
	localparam logic [KEY_W-1:0] KEY_ESCAPE    = 8'd27;
	localparam logic [KEY_W-1:0] BLANK_GLYPH   = 8'd32;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CURSOR = 2'd2;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_INIT,
		WR_ZERO,
		WR_BACK,
		WR_TYPE
	} wr_sel_t;

	typedef enum logic [2:0] {
		EM_CLEAR,
		EM_BACK,
		EM_TYPE,
		EM_CELL,
		EM_CURSOR
	} emit_sel_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_BACK,
		CUR_ADV,
		CUR_ZERO,
		CUR_RESTORE
	} cur_sel_t;

	typedef struct packed {
		logic      load_key;
		logic      init_adv;
		logic      cnt_clr;
		logic      cnt_adv;
		logic      page_adv;
		wr_sel_t   wr_sel;
		cur_sel_t  cur_sel;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic is_newline;
		logic is_back;
		logic is_return;
		logic is_escape;
		logic at_origin;
		logic cell_nonzero;
		logic cnt_last;
		logic init_last;
		logic out_free;
	} dp_status_t;

endpackage

### sv/pte_datapath.sv
// ----------------------------------------------------------------------------
// pte_datapath
// Page memory, cursor and page registers, saved cursors, cell counters and
// the output register of the paged text display editor.
// ----------------------------------------------------------------------------
module pte_datapath import pte_pkg::*; #(
	parameter int COLUMNS = 16,
	parameter int ROWS    = 2,
	parameter int PAGES   = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [KEY_W-1:0]      key_byte,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OP_W-1:0]       op,
	output logic [COL_OUT_W-1:0]  column,
	output logic [LINE_OUT_W-1:0] line,
	output logic [KEY_W-1:0]      glyph,
	output logic [PAGE_OUT_W-1:0] current_page,
	output logic                  last
);

	localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int CELLS = PAGES * ROWS * COLUMNS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);
	localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);

	function automatic logic [AW-1:0] cell_addr(
		input logic [PW-1:0] p,
		input logic [RW-1:0] r,
		input logic [CW-1:0] c
	);
		cell_addr = AW'((int'(p) * ROWS + int'(r)) * COLUMNS + int'(c));
	endfunction

	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    col_q, col_d, back_col, adv_col;
	logic [RW-1:0]    row_q, row_d, back_row, adv_row;
	logic [PW-1:0]    page_q, page_d;
	logic [CW-1:0]    saved_col_q [PAGES];
	logic [RW-1:0]    saved_row_q [PAGES];
	logic [CW-1:0]    ccol_q, ccol_d, ccol_step;
	logic [RW-1:0]    crow_q, crow_d, crow_step;
	logic [AW-1:0]    init_q;

	logic [KEY_W-1:0] mem [CELLS];
	logic [KEY_W-1:0] rd_data_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [KEY_W-1:0] wr_data;

	logic             out_valid_q;
	logic [OP_W-1:0]  op_q, em_op;
	logic [COL_OUT_W-1:0]  column_q;
	logic [LINE_OUT_W-1:0] line_q;
	logic [KEY_W-1:0]      glyph_q, em_glyph;
	logic [PAGE_OUT_W-1:0] page_out_q;
	logic                  last_q;
	logic [CW-1:0]    em_col;
	logic [RW-1:0]    em_row;

	always_comb begin
		back_col = col_q - 1'b1;
		back_row = row_q;
		if (col_q == '0) begin
			back_col = COL_LAST;
			back_row = (row_q == '0) ? ROW_LAST : row_q - 1'b1;
		end
	end

	always_comb begin
		adv_col = col_q + 1'b1;
		adv_row = row_q;
		if (col_q == COL_LAST) begin
			adv_col = '0;
			adv_row = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
		end
	end

	always_comb begin
		ccol_step = ccol_q + 1'b1;
		crow_step = crow_q;
		if (ccol_q == COL_LAST) begin
			ccol_step = '0;
			crow_step = (crow_q == ROW_LAST) ? '0 : crow_q + 1'b1;
		end
	end

	always_comb begin
		case (cmd.cur_sel)
			CUR_BACK: begin
				col_d = back_col;
				row_d = back_row;
			end
			CUR_ADV: begin
				col_d = adv_col;
				row_d = adv_row;
			end
			CUR_ZERO: begin
				col_d = '0;
				row_d = '0;
			end
			CUR_RESTORE: begin
				col_d = saved_col_q[page_q];
				row_d = saved_row_q[page_q];
			end
			default: begin
				col_d = col_q;
				row_d = row_q;
			end
		endcase
	end

	always_comb begin
		page_d = page_q;
		if (cmd.page_adv) begin
			page_d = (page_q == PAGE_LAST) ? '0 : page_q + 1'b1;
		end
	end

	always_comb begin
		ccol_d = ccol_q;
		crow_d = crow_q;
		if (cmd.cnt_clr) begin
			ccol_d = '0;
			crow_d = '0;
		end else if (cmd.cnt_adv) begin
			ccol_d = ccol_step;
			crow_d = crow_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			page_q <= '0;
			ccol_q <= '0;
			crow_q <= '0;
			init_q <= '0;
			for (int i = 0; i < PAGES; i++) begin
				saved_col_q[i] <= '0;
				saved_row_q[i] <= '0;
			end
		end else begin
			col_q  <= col_d;
			row_q  <= row_d;
			page_q <= page_d;
			ccol_q <= ccol_d;
			crow_q <= crow_d;
			if (cmd.init_adv) begin
				init_q <= (init_q == CELL_LAST) ? '0 : init_q + 1'b1;
			end
			if (cmd.page_adv) begin
				saved_col_q[page_q] <= col_q;
				saved_row_q[page_q] <= row_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= key_byte;
		end
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = '0;
		wr_data = '0;
		case (cmd.wr_sel)
			WR_INIT: wr_addr = init_q;
			WR_ZERO: wr_addr = cell_addr(page_q, crow_q, ccol_q);
			WR_BACK: begin
				wr_addr = cell_addr(page_q, back_row, back_col);
				wr_data = BLANK_GLYPH;
			end
			WR_TYPE: begin
				wr_addr = cell_addr(page_q, row_q, col_q);
				wr_data = key_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign rd_addr = cell_addr(page_d, crow_d, ccol_d);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		em_op    = OP_CLEAR;
		em_col   = '0;
		em_row   = '0;
		em_glyph = '0;
		case (cmd.emit_sel)
			EM_BACK: begin
				em_op    = OP_WRITE;
				em_col   = back_col;
				em_row   = back_row;
				em_glyph = BLANK_GLYPH;
			end
			EM_TYPE: begin
				em_op    = OP_WRITE;
				em_col   = col_q;
				em_row   = row_q;
				em_glyph = key_q;
			end
			EM_CELL: begin
				em_op    = OP_WRITE;
				em_col   = ccol_q;
				em_row   = crow_q;
				em_glyph = rd_data_q;
			end
			EM_CURSOR: em_op = OP_CURSOR;
			default: em_op = OP_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			op_q       <= em_op;
			column_q   <= COL_OUT_W'(em_col);
			line_q     <= LINE_OUT_W'(em_row);
			glyph_q    <= em_glyph;
			page_out_q <= PAGE_OUT_W'(page_d);
			last_q     <= cmd.emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign op           = op_q;
	assign column       = column_q;
	assign line         = line_q;
	assign glyph        = glyph_q;
	assign current_page = page_out_q;
	assign last         = last_q;

	assign status.is_newline   = (key_q == KEY_NEWLINE);
	assign status.is_back      = (key_q == KEY_BACKSPACE);
	assign status.is_return    = (key_q == KEY_RETURN);
	assign status.is_escape    = (key_q == KEY_ESCAPE);
	assign status.at_origin    = (col_q == '0) && (row_q == '0);
	assign status.cell_nonzero = (rd_data_q != '0);
	assign status.cnt_last     = (ccol_q == COL_LAST) && (crow_q == ROW_LAST);
	assign status.init_last    = (init_q == CELL_LAST);
	assign status.out_free     = !out_valid_q || out_ready;

endmodule

### sv/pte_ctrl.sv
// ----------------------------------------------------------------------------
// pte_ctrl
// Sequencer of the paged text display editor: memory clearing after reset,
// key dispatch, page sweeps, redraw walk and command issue.
// ----------------------------------------------------------------------------
module pte_ctrl import pte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [9:0] {
		S_INIT     = 10'b0000000001,
		S_IDLE     = 10'b0000000010,
		S_DISPATCH = 10'b0000000100,
		S_BACK     = 10'b0000001000,
		S_RET      = 10'b0000010000,
		S_REDRAW   = 10'b0000100000,
		S_CURSOR   = 10'b0001000000,
		S_CLEAR    = 10'b0010000000,
		S_SWEEP    = 10'b0100000000,
		S_TYPE     = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.wr_sel   = WR_INIT;
				cmd.init_adv = 1'b1;
				if (status.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_key = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (status.is_newline) begin
					state_d = S_IDLE;
				end else if (status.is_back) begin
					state_d = S_BACK;
				end else if (status.is_return) begin
					state_d = S_RET;
				end else if (status.is_escape || status.at_origin) begin
					state_d = S_CLEAR;
				end else begin
					state_d = S_TYPE;
				end
			end
			S_BACK: begin
				if (status.out_free) begin
					cmd.wr_sel    = WR_BACK;
					cmd.cur_sel   = CUR_BACK;
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_BACK;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_RET: begin
				if (status.out_free) begin
					cmd.page_adv = 1'b1;
					cmd.cnt_clr  = 1'b1;
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_CLEAR;
					state_d      = S_REDRAW;
				end
			end
			S_REDRAW: begin
				if (!status.cell_nonzero || status.out_free) begin
					cmd.cnt_adv  = 1'b1;
					cmd.emit     = status.cell_nonzero;
					cmd.emit_sel = EM_CELL;
					if (status.cnt_last) begin
						state_d = S_CURSOR;
					end
				end
			end
			S_CURSOR: begin
				if (status.out_free) begin
					cmd.cur_sel   = CUR_RESTORE;
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_CURSOR;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_CLEAR: begin
				if (status.out_free) begin
					cmd.cnt_clr   = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_CLEAR;
					cmd.emit_last = status.is_escape;
					if (status.is_escape) begin
						cmd.cur_sel = CUR_ZERO;
					end
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				cmd.wr_sel  = WR_ZERO;
				cmd.cnt_adv = 1'b1;
				if (status.cnt_last) begin
					state_d = status.is_escape ? S_IDLE : S_TYPE;
				end
			end
			S_TYPE: begin
				if (status.out_free) begin
					cmd.wr_sel    = WR_TYPE;
					cmd.cur_sel   = CUR_ADV;
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_TYPE;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

endmodule

### sv/paged_text_display_editor_top.sv
// ----------------------------------------------------------------------------
// paged_text_display_editor_top
// Turns received key bytes into display commands over several pages of
// character memory.
//
// The input channel (in_valid, in_ready, key_byte) takes one key item at a
// time. Every key other than newline yields a burst of display command items
// on the output channel (out_valid, out_ready, op, column, line, glyph,
// current_page, last); last marks the final item of the burst. Newline yields
// nothing. The block works on one key at a time.
// A plain character or backspace is written to the page memory and its command
// loaded into the output register. Escape sweeps the page cells; a character
// typed at the origin sweeps the page cells, then does the write. Carriage
// return redraws the next page by a walk that reads one cell a cycle from the
// page memory port while the output register is free or the cell is blank.
// After reset the page memory, PAGES*ROWS*COLUMNS cells (192 by default), is
// cleared one cell a cycle with in_ready low. A stalled receiver holds the
// pending command in the output register and the sequencer waits; no command
// is dropped.
// ----------------------------------------------------------------------------
module paged_text_display_editor_top import pte_pkg::*; #(
	parameter int COLUMNS = 16,
	parameter int ROWS    = 2,
	parameter int PAGES   = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KEY_W-1:0]      key_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OP_W-1:0]       op,
	output logic [COL_OUT_W-1:0]  column,
	output logic [LINE_OUT_W-1:0] line,
	output logic [KEY_W-1:0]      glyph,
	output logic [PAGE_OUT_W-1:0] current_page,
	output logic                  last
);

	dp_cmd_t    cmd;
	dp_status_t status;

	pte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pte_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.PAGES   (PAGES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_byte     (key_byte),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.op           (op),
		.column       (column),
		.line         (line),
		.glyph        (glyph),
		.current_page (current_page),
		.last         (last)
	);

endmodule

### sv/pte_checker.sv
// ----------------------------------------------------------------------------
// pte_checker
// Port-level checks of the paged text display editor, bound to the top level.
// ----------------------------------------------------------------------------
module pte_checker import pte_pkg::*; #(
	parameter int PAGES = 6
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [OP_W-1:0]       op,
	input logic [COL_OUT_W-1:0]  column,
	input logic [LINE_OUT_W-1:0] line,
	input logic [KEY_W-1:0]      glyph,
	input logic [PAGE_OUT_W-1:0] current_page,
	input logic                  last
);

	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (op == OP_CLEAR || op == OP_WRITE || op == OP_CURSOR))
		else $error("undefined display opcode");

	a_page_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(current_page) < PAGES))
		else $error("page out of range");

	a_clear_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && op == OP_CLEAR) |-> (column == '0 && line == '0 && glyph == '0))
		else $error("clear command carries position or glyph");

	a_burst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !in_ready)
		else $error("new key taken inside a command burst");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready held after accepting a key");

endmodule

bind paged_text_display_editor_top pte_checker #(.PAGES(PAGES)) u_pte_checker (.*);

### test/paged_text_display_editor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paged_text_display_editor_checker
// Watches the key and display command channels of the paged text display
// editor. Keeps its own copy of the pages, cursors and active page, works out
// the display commands that every accepted key item should cause, and
// compares each accepted command with the oldest one still expected.
// ----------------------------------------------------------------------------
module paged_text_display_editor_checker import pte_pkg::*; #(
	parameter int COLUMNS = 16,
	parameter int ROWS    = 2,
	parameter int PAGES   = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [KEY_W-1:0]      key_byte,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [OP_W-1:0]       op,
	input  logic [COL_OUT_W-1:0]  column,
	input  logic [LINE_OUT_W-1:0] line,
	input  logic [KEY_W-1:0]      glyph,
	input  logic [PAGE_OUT_W-1:0] current_page,
	input  logic                  last,
	output int                    mismatches,
	output int                    outstanding,
	output int                    commands_checked
);

	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [COL_OUT_W-1:0]  column;
		logic [LINE_OUT_W-1:0] line;
		logic [KEY_W-1:0]      glyph;
		logic [PAGE_OUT_W-1:0] current_page;
		logic                  last;
	} display_cmd_t;

	display_cmd_t     pending_cmds [$];
	logic [KEY_W-1:0] page_cells [PAGES][ROWS][COLUMNS];
	int               edit_col;
	int               edit_row;
	int               shown_page;
	int               kept_col [PAGES];
	int               kept_row [PAGES];

	function automatic void queue_cmd(input logic [OP_W-1:0] cmd_op, input int col, input int row,
			input logic [KEY_W-1:0] g);
		display_cmd_t c;
		c.op           = cmd_op;
		c.column       = COL_OUT_W'(col);
		c.line         = LINE_OUT_W'(row);
		c.glyph        = g;
		c.current_page = '0;
		c.last         = 1'b0;
		pending_cmds.push_back(c);
	endfunction

	function automatic void wipe_page(input int pg);
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLUMNS; c++)
				page_cells[pg][r][c] = '0;
	endfunction

	function automatic void take_key(input logic [KEY_W-1:0] key);
		int first;
		first = pending_cmds.size();
		if (key == KEY_NEWLINE)
			return;
		if (key == KEY_BACKSPACE) begin
			if (edit_col > 0) begin
				edit_col--;
			end else begin
				edit_col = COLUMNS - 1;
				edit_row = (edit_row > 0) ? edit_row - 1 : ROWS - 1;
			end
			page_cells[shown_page][edit_row][edit_col] = BLANK_GLYPH;
			queue_cmd(OP_WRITE, edit_col, edit_row, BLANK_GLYPH);
		end else if (key == KEY_RETURN) begin
			kept_col[shown_page] = edit_col;
			kept_row[shown_page] = edit_row;
			shown_page = (shown_page + 1 >= PAGES) ? 0 : shown_page + 1;
			queue_cmd(OP_CLEAR, 0, 0, '0);
			for (int r = 0; r < ROWS; r++)
				for (int c = 0; c < COLUMNS; c++)
					if (page_cells[shown_page][r][c] != '0)
						queue_cmd(OP_WRITE, c, r, page_cells[shown_page][r][c]);
			edit_col = kept_col[shown_page];
			edit_row = kept_row[shown_page];
			queue_cmd(OP_CURSOR, 0, 0, '0);
		end else if (key == KEY_ESCAPE) begin
			edit_col = 0;
			edit_row = 0;
			wipe_page(shown_page);
			queue_cmd(OP_CLEAR, 0, 0, '0);
		end else begin
			if (edit_col == 0 && edit_row == 0) begin
				wipe_page(shown_page);
				queue_cmd(OP_CLEAR, 0, 0, '0);
			end
			page_cells[shown_page][edit_row][edit_col] = key;
			queue_cmd(OP_WRITE, edit_col, edit_row, key);
			edit_col++;
			if (edit_col >= COLUMNS) begin
				edit_col = 0;
				edit_row++;
			end
			if (edit_row >= ROWS)
				edit_row = 0;
		end
		for (int i = first; i < pending_cmds.size(); i++)
			pending_cmds[i].current_page = PAGE_OUT_W'(shown_page);
		pending_cmds[pending_cmds.size() - 1].last = 1'b1;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		display_cmd_t want;
		if (!arst_n) begin
			for (int p = 0; p < PAGES; p++) begin
				wipe_page(p);
				kept_col[p] = 0;
				kept_row[p] = 0;
			end
			edit_col = 0;
			edit_row = 0;
			shown_page = 0;
			pending_cmds.delete();
			mismatches = 0;
			commands_checked = 0;
		end else begin
			if (in_valid && in_ready)
				take_key(key_byte);
			if (out_valid && out_ready) begin
				if (pending_cmds.size() == 0) begin
					$error("unexpected display command: op %0d column %0d line %0d glyph %0d",
						op, column, line, glyph);
					mismatches++;
				end else begin
					want = pending_cmds.pop_front();
					check_field("op", want.op, op);
					check_field("column", want.column, column);
					check_field("line", want.line, line);
					check_field("glyph", want.glyph, glyph);
					check_field("current_page", want.current_page, current_page);
					check_field("last", want.last, last);
					commands_checked++;
				end
			end
		end
		outstanding = pending_cmds.size();
	end

endmodule

### test/paged_text_display_editor_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paged_text_display_editor_top_test
// Feeds key items to the paged text display editor: a directed opening over
// every control key, wrap cases and extreme bytes, then random typing runs
// mixed with page changes, backspaces, clears and noise. Both channels idle at
// random and the receiver holds off once for a long stretch. The checker
// beside the block predicts and compares every display command.
// ----------------------------------------------------------------------------
module paged_text_display_editor_top_test import pte_pkg::*;;

	localparam int COLUMNS     = 16;
	localparam int ROWS        = 2;
	localparam int PAGES       = 6;
	localparam int RANDOM_KEYS = 156;

	logic                  clk       = 1'b0;
	logic                  arst_n;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [KEY_W-1:0]      key_byte  = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [OP_W-1:0]       op;
	logic [COL_OUT_W-1:0]  column;
	logic [LINE_OUT_W-1:0] line;
	logic [KEY_W-1:0]      glyph;
	logic [PAGE_OUT_W-1:0] current_page;
	logic                  last;

	int mismatches;
	int outstanding;
	int commands_checked;
	int keys_accepted = 0;
	int n_returns     = 0;
	int n_backs       = 0;
	int n_escapes     = 0;
	int n_newlines    = 0;
	int n_typed       = 0;

	paged_text_display_editor_top #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.PAGES  (PAGES)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key_byte    (key_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.op          (op),
		.column      (column),
		.line        (line),
		.glyph       (glyph),
		.current_page(current_page),
		.last        (last)
	);

	paged_text_display_editor_checker #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.PAGES  (PAGES)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_byte        (key_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.op              (op),
		.column          (column),
		.line            (line),
		.glyph           (glyph),
		.current_page    (current_page),
		.last            (last),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.commands_checked(commands_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (in_valid && in_ready)
			keys_accepted <= keys_accepted + 1;
	end

	function automatic bit quiet_window();
		return keys_accepted >= 110 && keys_accepted < 150;
	endfunction

	function automatic int pick_gap();
		if (quiet_window())
			return 0;
		if ($urandom_range(99) < 20)
			return $urandom_range(6, 1);
		return 0;
	endfunction

	function automatic logic [KEY_W-1:0] pick_glyph();
		if ($urandom_range(9) == 0)
			return KEY_W'($urandom_range(255));
		return KEY_W'($urandom_range(126, 32));
	endfunction

	// hold valid high across back-to-back items; drop it only for a gap
	task automatic send_key(input logic [KEY_W-1:0] k, input int gap);
		in_valid <= 1'b1;
		key_byte <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		case (k)
			KEY_RETURN:    n_returns++;
			KEY_BACKSPACE: n_backs++;
			KEY_ESCAPE:    n_escapes++;
			KEY_NEWLINE:   n_newlines++;
			default:       n_typed++;
		endcase
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver: one long hold-off so the block fills up, then random stalls
	initial begin
		int hold_left;
		bit held;
		held = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && keys_accepted >= 60) begin
				held = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (quiet_window()) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 20);
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] directed_keys [$];
		int random_keys;
		int pick;
		int run;
		directed_keys = '{
			8'h48, 8'h69, 8'h00, 8'hFF, KEY_BACKSPACE, KEY_BACKSPACE,
			KEY_BACKSPACE, KEY_BACKSPACE, KEY_BACKSPACE, 8'h78, 8'h79,
			KEY_NEWLINE, KEY_RETURN, 8'h41, KEY_RETURN, KEY_RETURN, KEY_RETURN,
			KEY_RETURN, KEY_RETURN, KEY_ESCAPE, 8'h7F, 8'h80, KEY_RETURN, KEY_ESCAPE
		};
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_keys[i])
			send_key(directed_keys[i], pick_gap());

		random_keys = 0;
		while (random_keys < RANDOM_KEYS) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				run = $urandom_range(40, 1);
				if (run > RANDOM_KEYS - random_keys)
					run = RANDOM_KEYS - random_keys;
				repeat (run) begin
					send_key(pick_glyph(), pick_gap());
					random_keys++;
				end
			end else if (pick < 70) begin
				run = $urandom_range(4, 1);
				if (run > RANDOM_KEYS - random_keys)
					run = RANDOM_KEYS - random_keys;
				repeat (run) begin
					send_key(KEY_BACKSPACE, pick_gap());
					random_keys++;
				end
			end else if (pick < 85) begin
				send_key(KEY_RETURN, pick_gap());
				random_keys++;
			end else if (pick < 92) begin
				send_key(KEY_ESCAPE, pick_gap());
				random_keys++;
			end else if ($urandom_range(2) == 0) begin
				send_key(KEY_NEWLINE, pick_gap());
				random_keys++;
			end else begin
				send_key(KEY_W'($urandom_range(255)), pick_gap());
				random_keys++;
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run covered %0d keys: %0d typed, %0d backspaces, %0d page changes,",
			keys_accepted, n_typed, n_backs, n_returns);
		$display("%0d page clears and %0d newlines; %0d display commands checked.",
			n_escapes, n_newlines, commands_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
